[rtl/islip_pkg.sv]
// Shared constants, result codes and controller/datapath interface types
// for the iSLIP crossbar scheduler. No dependencies.
package islip_pkg;

  localparam int PORTS        = 8;
  localparam int QUEUE_DEPTH  = 16;
  localparam int PORT_W       = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int NUM_W        = $clog2(PORTS + 1);
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W       = 2 * PORT_W;
  localparam int FIELD_W      = 4;
  localparam int CFG_W        = 5;
  localparam int ACTIVE_RESET = 8;
  localparam int MIN_PORTS    = 2;

  typedef enum logic [1:0] {
    KIND_ARRIVAL = 2'd0,
    KIND_MATCH   = 2'd1,
    KIND_EMPTY   = 2'd2
  } kind_t;

  typedef struct packed {
    logic take;
    logic arr_done;
    logic grant;
    logic scan;
    logic pop;
    logic next_iter;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic ip_last;
    logic again;
    logic out_free;
    logic pend_valid;
  } dp_status_t;

endpackage

[rtl/islip_ctrl.sv]
// Sequencing state machine for the iSLIP scheduler.
// Depends on islip_pkg for the command and status types.
module islip_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   operation,
  input  islip_pkg::dp_status_t  status,
  output islip_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ARR   = 7'b0000010,
    S_GRANT = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_POP   = 7'b0010000,
    S_ITER  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && in_ready) begin
          cmd.take   = 1'b1;
          state_next = operation ? S_GRANT : S_ARR;
        end
      end
      S_ARR: begin
        if (status.out_free) begin
          cmd.arr_done = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_GRANT: begin
        cmd.grant  = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.hit) begin
          state_next = S_POP;
        end else if (status.ip_last) begin
          state_next = S_ITER;
        end
      end
      S_POP: begin
        if (!status.pend_valid || status.out_free) begin
          cmd.pop    = 1'b1;
          state_next = status.ip_last ? S_ITER : S_SCAN;
        end
      end
      S_ITER: begin
        if (status.again) begin
          cmd.next_iter = 1'b1;
          state_next    = S_GRANT;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/islip_dp.sv]
// Datapath of the iSLIP scheduler: queue counts, arbiters, pointers and
// the result register. Depends on islip_pkg; driven by islip_ctrl.
module islip_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [islip_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic [islip_pkg::FIELD_W-1:0]       in_port,
  input  logic [islip_pkg::FIELD_W-1:0]       out_port,
  input  islip_pkg::ctrl_cmd_t                cmd,
  output islip_pkg::dp_status_t               status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [1:0]                          kind,
  output logic [islip_pkg::FIELD_W-1:0]       match_input,
  output logic [islip_pkg::FIELD_W-1:0]       match_output,
  output logic                                dropped,
  output logic                                last
);

  localparam int P  = islip_pkg::PORTS;
  localparam int PW = islip_pkg::PORT_W;
  localparam int NW = islip_pkg::NUM_W;
  localparam int CW = islip_pkg::CNT_W;
  localparam int AW = islip_pkg::ADDR_W;
  localparam int FW = islip_pkg::FIELD_W;
  localparam int GW = islip_pkg::CFG_W;

  typedef struct packed {
    logic          found;
    logic [PW-1:0] idx;
  } pick_t;

  // Round-robin pick: first request at or above start, else lowest request.
  function automatic pick_t rr_pick(input logic [P-1:0] req, input logic [PW-1:0] start);
    pick_t hi;
    pick_t any;
    hi  = '0;
    any = '0;
    for (int i = P - 1; i >= 0; i--) begin
      if (req[i]) begin
        any.found = 1'b1;
        any.idx   = PW'(i);
        if (PW'(i) >= start) begin
          hi.found = 1'b1;
          hi.idx   = PW'(i);
        end
      end
    end
    return hi.found ? hi : any;
  endfunction

  function automatic logic [PW-1:0] clip(input logic [PW-1:0] p, input logic [NW-1:0] num);
    return (NW'(p) < num) ? p : '0;
  endfunction

  function automatic logic [PW-1:0] next_port(input logic [PW-1:0] p,
                                              input logic [NW-1:0] num);
    logic [NW-1:0] inc;
    inc = NW'(p) + NW'(1);
    return (inc == num) ? '0 : inc[PW-1:0];
  endfunction

  logic [GW-1:0] active_ports;
  logic [NW-1:0] n;
  logic [P-1:0]  nonempty [P];
  logic [PW-1:0] grant_pointer [P];
  logic [PW-1:0] accept_pointer [P];
  logic [P-1:0]  in_busy;
  logic [P-1:0]  out_busy;
  logic [P-1:0]  granted;
  logic [PW-1:0] grant_to [P];
  logic [PW-1:0] ipc;
  logic [PW-1:0] cand;
  logic [NW-1:0] iter;
  logic          conn;
  logic          pend_valid;
  logic [PW-1:0] pend_ip;
  logic [PW-1:0] pend_op;
  logic [FW-1:0] req_ip;
  logic [FW-1:0] req_op;

  logic [CW-1:0] mem [2**AW];
  logic [CW-1:0] rd_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] wr_data;

  logic [P-1:0]  req_col [P];
  pick_t         gr_pick [P];
  logic [P-1:0]  gr_found;
  logic [P-1:0]  acc_req;
  pick_t         acc_pick;
  logic [CW-1:0] arr_cnt;
  logic          arr_ok;

  always_comb begin
    if (active_ports < GW'(islip_pkg::MIN_PORTS)) begin
      n = NW'(islip_pkg::MIN_PORTS);
    end else if (active_ports > GW'(P)) begin
      n = NW'(P);
    end else begin
      n = active_ports[NW-1:0];
    end
  end

  // Grant phase: one arbiter per output over the free inputs
  always_comb begin
    for (int o = 0; o < P; o++) begin
      for (int i = 0; i < P; i++) begin
        req_col[o][i] = nonempty[i][o] && !in_busy[i] && (NW'(i) < n);
      end
      gr_pick[o]  = rr_pick(req_col[o], clip(grant_pointer[o], n));
      gr_found[o] = gr_pick[o].found && !out_busy[o] && (NW'(o) < n);
    end
  end

  // Accept phase: one shared arbiter, stepped across the inputs
  always_comb begin
    for (int c = 0; c < P; c++) begin
      acc_req[c] = granted[c] && (grant_to[c] == ipc) && !out_busy[c];
    end
    acc_pick = rr_pick(acc_req, clip(accept_pointer[ipc], n));
  end

  assign arr_cnt = nonempty[req_ip[PW-1:0]][req_op[PW-1:0]] ? rd_data : '0;
  assign arr_ok  = (GW'(req_ip) < GW'(n)) && (GW'(req_op) < GW'(n)) &&
                   (arr_cnt < CW'(islip_pkg::QUEUE_DEPTH));

  assign status.hit        = acc_pick.found && !in_busy[ipc];
  assign status.ip_last    = (NW'(ipc) == n - NW'(1));
  assign status.again      = conn && (iter < n);
  assign status.out_free   = !out_valid || out_ready;
  assign status.pend_valid = pend_valid;

  assign rd_en   = cmd.take || (cmd.scan && status.hit);
  assign rd_addr = cmd.take ? {in_port[PW-1:0], out_port[PW-1:0]} : {ipc, acc_pick.idx};
  assign wr_en   = (cmd.arr_done && arr_ok) || cmd.pop;
  assign wr_addr = cmd.pop ? {ipc, cand} : {req_ip[PW-1:0], req_op[PW-1:0]};
  assign wr_data = cmd.pop ? rd_data - CW'(1) : arr_cnt + CW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_ports <= GW'(islip_pkg::ACTIVE_RESET);
      for (int i = 0; i < P; i++) begin
        nonempty[i]       <= '0;
        grant_pointer[i]  <= '0;
        accept_pointer[i] <= '0;
      end
      in_busy    <= '0;
      out_busy   <= '0;
      granted    <= '0;
      ipc        <= '0;
      iter       <= '0;
      conn       <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        active_ports <= cfg_wr_data;
      end
      if (cmd.take) begin
        in_busy    <= '0;
        out_busy   <= '0;
        iter       <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.grant) begin
        granted <= gr_found;
        ipc     <= '0;
        conn    <= 1'b0;
      end
      if (cmd.scan) begin
        if (status.hit) begin
          in_busy[ipc]          <= 1'b1;
          out_busy[acc_pick.idx] <= 1'b1;
          conn                  <= 1'b1;
          if (iter == '0) begin
            accept_pointer[ipc]          <= next_port(acc_pick.idx, n);
            grant_pointer[acc_pick.idx]  <= next_port(ipc, n);
          end
        end else if (!status.ip_last) begin
          ipc <= ipc + PW'(1);
        end
      end
      if (cmd.pop) begin
        nonempty[ipc][cand] <= (rd_data != CW'(1));
        pend_valid          <= 1'b1;
        if (!status.ip_last) begin
          ipc <= ipc + PW'(1);
        end
      end
      if (cmd.arr_done && arr_ok) begin
        nonempty[req_ip[PW-1:0]][req_op[PW-1:0]] <= 1'b1;
      end
      if (cmd.next_iter) begin
        iter <= iter + NW'(1);
      end
      if (cmd.finish) begin
        pend_valid <= 1'b0;
      end
      if (cmd.arr_done || (cmd.pop && pend_valid) || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_ip <= in_port;
      req_op <= out_port;
    end
    if (cmd.grant) begin
      for (int o = 0; o < P; o++) begin
        grant_to[o] <= gr_pick[o].idx;
      end
    end
    if (cmd.scan && status.hit) begin
      cand <= acc_pick.idx;
    end
    if (cmd.pop) begin
      pend_ip <= ipc;
      pend_op <= cand;
    end
    if (cmd.arr_done) begin
      kind         <= islip_pkg::KIND_ARRIVAL;
      match_input  <= req_ip;
      match_output <= req_op;
      dropped      <= !arr_ok;
      last         <= 1'b1;
    end else if (cmd.pop && pend_valid) begin
      kind         <= islip_pkg::KIND_MATCH;
      match_input  <= FW'(pend_ip);
      match_output <= FW'(pend_op);
      dropped      <= 1'b0;
      last         <= 1'b0;
    end else if (cmd.finish) begin
      kind         <= pend_valid ? islip_pkg::KIND_MATCH : islip_pkg::KIND_EMPTY;
      match_input  <= pend_valid ? FW'(pend_ip) : '0;
      match_output <= pend_valid ? FW'(pend_op) : '0;
      dropped      <= 1'b0;
      last         <= 1'b1;
    end
  end

endmodule

[rtl/islip_voq_switch_scheduler.sv]
// Top level of the iSLIP crossbar scheduler with virtual output queues.
// Depends on islip_pkg, islip_ctrl and islip_dp.
//
// An arrival word adds one packet to the count of its input-output queue and
// has its acknowledgement written to the output register from the arrival
// state once that register is free, flagged as dropped when the queue is
// full or a port is not below the active port count (active_ports clamped
// to 2..PORTS). A slot word runs iSLIP iterations until one adds no match or
// the iteration counter reaches that count; each match comes out as its own
// result, the final one marked last, or a single empty result when nothing
// matched. The grant arbiters of all outputs settle together in the grant
// step, while the accept arbiter is shared and steps one input a cycle,
// pausing at each match for a pop step that writes back its decremented
// queue count and waits for the output register when a result is pending.
// A result that is not taken holds the next one back. One word is in work
// at a time; the next is taken as soon as the last result of the previous
// one sits in the output register. No clearing pass is needed after reset.
module islip_voq_switch_scheduler (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [islip_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           operation,
  input  logic [islip_pkg::FIELD_W-1:0]  in_port,
  input  logic [islip_pkg::FIELD_W-1:0]  out_port,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     kind,
  output logic [islip_pkg::FIELD_W-1:0]  match_input,
  output logic [islip_pkg::FIELD_W-1:0]  match_output,
  output logic                           dropped,
  output logic                           last
);

  islip_pkg::ctrl_cmd_t  cmd;
  islip_pkg::dp_status_t status;

  islip_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .status    (status),
    .cmd       (cmd)
  );

  islip_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_port      (in_port),
    .out_port     (out_port),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .kind         (kind),
    .match_input  (match_input),
    .match_output (match_output),
    .dropped      (dropped),
    .last         (last)
  );

endmodule
